>>> src/sphere_polyline_collision_defines.svh
// ----------------------------------------------------------------------------
// Sphere / polyline collision: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPHERE_POLYLINE_COLLISION_DEFINES_SVH
`define SPHERE_POLYLINE_COLLISION_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define SPL_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define SPL_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spl_pkg.sv
// ----------------------------------------------------------------------------
// Sphere / polyline collision package
// Widths, register indexes, shift codes and the multiply-accumulate command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spl_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int RADIUS_W   = 15;
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Arithmetic widths
    localparam int DIFF_W = COORD_W + 1;     // coordinate difference
    localparam int OP_W   = DIFF_W + 1;      // multiplier operand
    localparam int PROD_W = 2 * OP_W;        // multiplier product
    localparam int HALF_W = DIFF_W;          // half of a wide operand
    localparam int WIDE_W = 2 * HALF_W;      // wide unsigned operand
    localparam int SUM_W  = WIDE_W + 1;      // signed sum of squares
    localparam int ACC_W  = 2 * WIDE_W + 2;  // accumulator

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(112);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = CFG_IDX_W'(3);

    // Product alignment codes
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_HALF = 2'd1;
    localparam logic [1:0] SH_FULL = 2'd2;

    // One multiply-accumulate operation
    typedef struct packed {
        logic                   en;
        logic                   clear;
        logic                   sub;
        logic [1:0]             shift;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } mac_cmd_t;

endpackage

>>> src/spl_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One 18x18 signed multiplier feeding a 70-bit accumulator, with the
// product aligned by none, one half or two halves of a wide operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spl_mac
(
    input  logic                             clk,
    input  spl_pkg::mac_cmd_t                cmd,
    output logic signed [spl_pkg::ACC_W-1:0] acc
);

    logic signed [spl_pkg::OP_W-1:0]   a_op;
    logic signed [spl_pkg::OP_W-1:0]   b_op;
    logic signed [spl_pkg::PROD_W-1:0] prod;
    logic signed [spl_pkg::ACC_W-1:0]  prod_ext;
    logic signed [spl_pkg::ACC_W-1:0]  prod_aligned;
    logic signed [spl_pkg::ACC_W-1:0]  acc_base;
    logic signed [spl_pkg::ACC_W-1:0]  acc_reg;
    logic signed [spl_pkg::ACC_W-1:0]  acc_next;

    // Multiply and sign-extend
    assign a_op     = cmd.a;
    assign b_op     = cmd.b;
    assign prod     = a_op * b_op;
    assign prod_ext = {{(spl_pkg::ACC_W - spl_pkg::PROD_W){prod[spl_pkg::PROD_W-1]}}, prod};

    // Align the partial product
    always_comb
    begin
        case (cmd.shift)
            spl_pkg::SH_NONE: prod_aligned = prod_ext;
            spl_pkg::SH_HALF: prod_aligned = prod_ext <<< spl_pkg::HALF_W;
            spl_pkg::SH_FULL: prod_aligned = prod_ext <<< (2 * spl_pkg::HALF_W);
            default:          prod_aligned = prod_ext;
        endcase
    end

    // Add or subtract into a fresh or running sum
    assign acc_base = cmd.clear ? '0 : acc_reg;
    assign acc_next = cmd.sub ? (acc_base - prod_aligned) : (acc_base + prod_aligned);

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> src/spl_seq.sv
// ----------------------------------------------------------------------------
// Sphere / polyline collision sequencer
// Holds the point and the previous point, steps the shared multiply-
// accumulate unit through the segment test and latches the hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spl_seq
(
    input  logic                                clk,
    input  logic                                rst_n,
    // point word
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [spl_pkg::COORD_W-1:0]         in_x,
    input  logic [spl_pkg::COORD_W-1:0]         in_y,
    input  logic [spl_pkg::COORD_W-1:0]         in_z,
    input  logic                                in_last,
    // sphere
    input  logic [spl_pkg::COORD_W-1:0]         center_x,
    input  logic [spl_pkg::COORD_W-1:0]         center_y,
    input  logic [spl_pkg::COORD_W-1:0]         center_z,
    input  logic [spl_pkg::RADIUS_W-1:0]        radius,
    // result
    input  logic                                res_ready,
    output logic                                res_valid,
    output logic                                res_collided,
    // shared unit
    output spl_pkg::mac_cmd_t                   mac_cmd,
    input  logic signed [spl_pkg::ACC_W-1:0]    acc
);

    localparam int DIFF_W = spl_pkg::DIFF_W;
    localparam int OP_W   = spl_pkg::OP_W;
    localparam int HALF_W = spl_pkg::HALF_W;
    localparam int SUM_W  = spl_pkg::SUM_W;

    // States
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Steps of the segment test
    localparam logic [4:0] STEP_R2_A   = 5'd0;   // -r^2 for the first end
    localparam logic [4:0] STEP_WX     = 5'd1;
    localparam logic [4:0] STEP_WY     = 5'd2;
    localparam logic [4:0] STEP_WZ     = 5'd3;
    localparam logic [4:0] STEP_R2_B   = 5'd4;   // -r^2 for the second end
    localparam logic [4:0] STEP_VX     = 5'd5;
    localparam logic [4:0] STEP_VY     = 5'd6;
    localparam logic [4:0] STEP_VZ     = 5'd7;
    localparam logic [4:0] STEP_DX     = 5'd8;
    localparam logic [4:0] STEP_DY     = 5'd9;
    localparam logic [4:0] STEP_DZ     = 5'd10;
    localparam logic [4:0] STEP_DWX    = 5'd11;
    localparam logic [4:0] STEP_DWY    = 5'd12;
    localparam logic [4:0] STEP_DWZ    = 5'd13;
    localparam logic [4:0] STEP_DECIDE = 5'd14;
    localparam logic [4:0] STEP_RHS_LL = 5'd15;  // dw^2 partial products
    localparam logic [4:0] STEP_RHS_LH = 5'd16;
    localparam logic [4:0] STEP_RHS_HL = 5'd17;
    localparam logic [4:0] STEP_RHS_HH = 5'd18;
    localparam logic [4:0] STEP_LHS_LL = 5'd19;  // (w2 - r2) * dd partial products
    localparam logic [4:0] STEP_LHS_LH = 5'd20;
    localparam logic [4:0] STEP_LHS_HL = 5'd21;
    localparam logic [4:0] STEP_LHS_HH = 5'd22;
    localparam logic [4:0] STEP_SIGN   = 5'd23;

    logic [1:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       have_prev_reg, have_prev_next;
    logic       hit_reg, hit_next;
    logic       finish_go;

    logic [spl_pkg::COORD_W-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic                        last_reg;
    logic [spl_pkg::COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;

    logic signed [SUM_W-1:0] e1_reg;   // |c - p1|^2 - r^2
    logic signed [SUM_W-1:0] e2_reg;   // |p2 - c|^2 - r^2
    logic signed [SUM_W-1:0] dd_reg;   // dot(d, d)
    logic signed [SUM_W-1:0] dw_reg;   // dot(d, w)
    logic signed [SUM_W-1:0] dw_now;

    logic signed [DIFF_W-1:0] w_x, w_y, w_z;
    logic signed [DIFF_W-1:0] v_x, v_y, v_z;
    logic signed [DIFF_W-1:0] d_x, d_y, d_z;
    logic signed [OP_W-1:0]   rad_op;
    logic signed [OP_W-1:0]   dw_lo, dw_hi, e1_lo, e1_hi, dd_lo, dd_hi;

    logic end_hit;
    logic mid_ok;
    logic acc_pos;

    function automatic logic signed [DIFF_W-1:0] diff(input logic [spl_pkg::COORD_W-1:0] p,
                                                      input logic [spl_pkg::COORD_W-1:0] q);
        logic signed [DIFF_W-1:0] ps;
        logic signed [DIFF_W-1:0] qs;
        ps = {p[spl_pkg::COORD_W-1], p};
        qs = {q[spl_pkg::COORD_W-1], q};
        return ps - qs;
    endfunction

    function automatic logic signed [OP_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
        return {v[DIFF_W-1], v};
    endfunction

    // Segment vectors: w = c - p1, v = p2 - c, d = p2 - p1
    assign w_x = diff(center_x, prev_x_reg);
    assign w_y = diff(center_y, prev_y_reg);
    assign w_z = diff(center_z, prev_z_reg);
    assign v_x = diff(pt_x_reg, center_x);
    assign v_y = diff(pt_y_reg, center_y);
    assign v_z = diff(pt_z_reg, center_z);
    assign d_x = diff(pt_x_reg, prev_x_reg);
    assign d_y = diff(pt_y_reg, prev_y_reg);
    assign d_z = diff(pt_z_reg, prev_z_reg);

    // Halves of the wide operands, zero-extended
    assign rad_op = {{(OP_W - spl_pkg::RADIUS_W){1'b0}}, radius};
    assign dw_lo  = {1'b0, dw_reg[HALF_W-1:0]};
    assign dw_hi  = {1'b0, dw_reg[2*HALF_W-1:HALF_W]};
    assign e1_lo  = {1'b0, e1_reg[HALF_W-1:0]};
    assign e1_hi  = {1'b0, e1_reg[2*HALF_W-1:HALF_W]};
    assign dd_lo  = {1'b0, dd_reg[HALF_W-1:0]};
    assign dd_hi  = {1'b0, dd_reg[2*HALF_W-1:HALF_W]};

    // Decisions on the sums
    assign dw_now  = acc[SUM_W-1:0];
    assign end_hit = e1_reg[SUM_W-1] | e2_reg[SUM_W-1];
    assign mid_ok  = (dd_reg > 0) && (dw_now > 0) && (dw_now < dd_reg);
    assign acc_pos = !acc[spl_pkg::ACC_W-1] && (acc != '0);

    // Issue one operation per step, none on the decide and sign steps
    always_comb
    begin
        mac_cmd       = '0;
        mac_cmd.shift = spl_pkg::SH_NONE;
        if (state_reg == ST_RUN)
        begin
            mac_cmd.en = 1'b1;
            case (step_reg)
                STEP_R2_A, STEP_R2_B:
                begin
                    mac_cmd.clear = 1'b1;
                    mac_cmd.sub   = 1'b1;
                    mac_cmd.a     = rad_op;
                    mac_cmd.b     = rad_op;
                end
                STEP_WX: begin mac_cmd.a = sx(w_x); mac_cmd.b = sx(w_x); end
                STEP_WY: begin mac_cmd.a = sx(w_y); mac_cmd.b = sx(w_y); end
                STEP_WZ: begin mac_cmd.a = sx(w_z); mac_cmd.b = sx(w_z); end
                STEP_VX: begin mac_cmd.a = sx(v_x); mac_cmd.b = sx(v_x); end
                STEP_VY: begin mac_cmd.a = sx(v_y); mac_cmd.b = sx(v_y); end
                STEP_VZ: begin mac_cmd.a = sx(v_z); mac_cmd.b = sx(v_z); end
                STEP_DX:
                begin
                    mac_cmd.clear = 1'b1;
                    mac_cmd.a     = sx(d_x);
                    mac_cmd.b     = sx(d_x);
                end
                STEP_DY: begin mac_cmd.a = sx(d_y); mac_cmd.b = sx(d_y); end
                STEP_DZ: begin mac_cmd.a = sx(d_z); mac_cmd.b = sx(d_z); end
                STEP_DWX:
                begin
                    mac_cmd.clear = 1'b1;
                    mac_cmd.a     = sx(d_x);
                    mac_cmd.b     = sx(w_x);
                end
                STEP_DWY: begin mac_cmd.a = sx(d_y); mac_cmd.b = sx(w_y); end
                STEP_DWZ: begin mac_cmd.a = sx(d_z); mac_cmd.b = sx(w_z); end
                STEP_RHS_LL:
                begin
                    mac_cmd.clear = 1'b1;
                    mac_cmd.a     = dw_lo;
                    mac_cmd.b     = dw_lo;
                end
                STEP_RHS_LH:
                begin
                    mac_cmd.a     = dw_lo;
                    mac_cmd.b     = dw_hi;
                    mac_cmd.shift = spl_pkg::SH_HALF;
                end
                STEP_RHS_HL:
                begin
                    mac_cmd.a     = dw_hi;
                    mac_cmd.b     = dw_lo;
                    mac_cmd.shift = spl_pkg::SH_HALF;
                end
                STEP_RHS_HH:
                begin
                    mac_cmd.a     = dw_hi;
                    mac_cmd.b     = dw_hi;
                    mac_cmd.shift = spl_pkg::SH_FULL;
                end
                STEP_LHS_LL:
                begin
                    mac_cmd.sub = 1'b1;
                    mac_cmd.a   = e1_lo;
                    mac_cmd.b   = dd_lo;
                end
                STEP_LHS_LH:
                begin
                    mac_cmd.sub   = 1'b1;
                    mac_cmd.a     = e1_lo;
                    mac_cmd.b     = dd_hi;
                    mac_cmd.shift = spl_pkg::SH_HALF;
                end
                STEP_LHS_HL:
                begin
                    mac_cmd.sub   = 1'b1;
                    mac_cmd.a     = e1_hi;
                    mac_cmd.b     = dd_lo;
                    mac_cmd.shift = spl_pkg::SH_HALF;
                end
                STEP_LHS_HH:
                begin
                    mac_cmd.sub   = 1'b1;
                    mac_cmd.a     = e1_hi;
                    mac_cmd.b     = dd_hi;
                    mac_cmd.shift = spl_pkg::SH_FULL;
                end
                default: mac_cmd.en = 1'b0;
            endcase
        end
    end

    // Leave the finish state at once after a point that is not last, or once a final answer can be handed over
    assign finish_go = (state_reg == ST_FINISH) && (!last_reg || res_ready);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        have_prev_next = have_prev_reg;
        hit_next       = hit_reg;
        res_valid      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    step_next  = STEP_R2_A;
                    state_next = have_prev_reg ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == STEP_DECIDE)
                begin
                    if (end_hit)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (!mid_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (step_reg == STEP_SIGN)
                begin
                    if (acc_pos)
                    begin
                        hit_next = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next     = ST_IDLE;
                    have_prev_next = !last_reg;
                    if (last_reg)
                    begin
                        res_valid = 1'b1;
                        hit_next  = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign res_collided = hit_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_R2_A;
            have_prev_reg <= 1'b0;
            hit_reg       <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            have_prev_reg <= have_prev_next;
            hit_reg       <= hit_next;
            if (finish_go)
            begin
                prev_x_reg <= pt_x_reg;
                prev_y_reg <= pt_y_reg;
                prev_z_reg <= pt_z_reg;
            end
        end
    end

    // Capture the point word and the intermediate sums
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pt_x_reg <= in_x;
            pt_y_reg <= in_y;
            pt_z_reg <= in_z;
            last_reg <= in_last;
        end
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STEP_R2_B:   e1_reg <= acc[SUM_W-1:0];
                STEP_DX:     e2_reg <= acc[SUM_W-1:0];
                STEP_DWX:    dd_reg <= acc[SUM_W-1:0];
                STEP_DECIDE: dw_reg <= acc[SUM_W-1:0];
                default:     ;
            endcase
        end
    end

endmodule

>>> src/sphere_polyline_collision.sv
// ----------------------------------------------------------------------------
// Sphere / polyline collision
// Tests each segment of a streamed polyline against a configured sphere
// and reports on the last point whether any segment touched it.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: point_x, point_y, point_z
//                                          tlast: last_point
// m_axis    out  m_axis_tvalid/tready      tdata: collided
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A first point of a polyline only becomes the start of the first segment.
// A later point runs the segment test, which ends early when an endpoint is
// inside or the middle cannot hit; the single 18x18 multiply-accumulate unit
// takes one partial product a cycle. Reset is asynchronous, active low, with
// no clearing pass. On a last point the block holds in its finish step until
// the output register is free; configuration writes are always taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sphere_polyline_collision_defines.svh"

module sphere_polyline_collision
(
    input  logic                               clk,
    input  logic                               rst_n,
    // point words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [spl_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // point_x, point_y, point_z
    input  logic                               s_axis_tlast,   // last_point
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [spl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // collided, zero fill
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COORD_W = spl_pkg::COORD_W;

    logic [COORD_W-1:0]           center_x_reg;
    logic [COORD_W-1:0]           center_y_reg;
    logic [COORD_W-1:0]           center_z_reg;
    logic [spl_pkg::RADIUS_W-1:0] radius_reg;

    logic                              out_valid_reg;
    logic                              out_collided_reg;
    logic                              res_ready;
    logic                              res_valid;
    logic                              res_collided;
    spl_pkg::mac_cmd_t                 mac_cmd;
    logic signed [spl_pkg::ACC_W-1:0] acc;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= spl_pkg::RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spl_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                spl_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                spl_pkg::CFG_CENTER_Z: center_z_reg <= cfg_data;
                spl_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[spl_pkg::RADIUS_W-1:0];
                default:               ;
            endcase
        end
    end

    // Sequencer
    spl_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_x         (s_axis_tdata[COORD_W-1:0]),
        .in_y         (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .in_z         (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .in_last      (s_axis_tlast),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .center_z     (center_z_reg),
        .radius       (radius_reg),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res_collided (res_collided),
        .mac_cmd      (mac_cmd),
        .acc          (acc)
    );

    // Shared multiply-accumulate unit
    spl_mac u_mac
    (
        .clk (clk),
        .cmd (mac_cmd),
        .acc (acc)
    );

    // Output register: load a result word, drop it once taken
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_collided_reg <= res_collided;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(spl_pkg::OUT_DATA_W - 1){1'b0}}, out_collided_reg};

    // Checks
    `SPL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "point accepted but block still ready")
    `SPL_ASSERT_SAME(a_result_room, clk, rst_n, res_valid, !out_valid_reg || m_axis_tready, "result word loaded over a pending one")
    `SPL_ASSERT_SAME(a_result_busy, clk, rst_n, res_valid, !s_axis_tready, "result word produced while idle")

endmodule

>>> sim/sphere_polyline_collision_tb.sv
// ----------------------------------------------------------------------------
// Sphere / polyline collision testbench
// Streams polylines into the block and checks each collided word against a
// bit-exact predictor of the segment test. Several sphere settings are
// used, the extremes among them. Points are sent in bursts with gaps, and
// results are taken under a changing stall pattern that includes one long
// hold-off, which fills the block and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_polyline_collision_tb;

    localparam int COORD_W    = spl_pkg::COORD_W;
    localparam int RADIUS_W   = spl_pkg::RADIUS_W;
    localparam int IN_DATA_W  = spl_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = spl_pkg::OUT_DATA_W;
    localparam int CFG_IDX_W  = spl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = spl_pkg::CFG_DATA_W;

    // Writes to these indexes have no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = CFG_IDX_W'(255);

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // point_x, point_y, point_z
    logic                  s_axis_tlast = 1'b0; // last_point
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // collided, zero fill
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Points waiting for the driver, and collided flags still owed
    point_t pending_points[$];
    bit     collided_due[$];
    int     errors = 0;

    // Sphere and polyline state as the block should hold it
    logic signed [COORD_W-1:0] ctr_x = '0;
    logic signed [COORD_W-1:0] ctr_y = '0;
    logic signed [COORD_W-1:0] ctr_z = '0;
    logic [RADIUS_W-1:0]       radius = spl_pkg::RADIUS_RESET;
    point_t                    prev_pt = '0;
    bit                        have_prev = 1'b0;
    bit                        hit_latch = 1'b0;

    bit s_fire = 1'b0;
    bit hold_req = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int rx_mode = 0;
    logic [5:0] rx_count = '0;

    sphere_polyline_collision i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Exact squared test of segment a-b against the current sphere
    function automatic bit segment_touches(point_t a, point_t b);
        longint      r2, wa2, wb2, dx, dy, dz, wx, wy, wz, dd, dw;
        logic [127:0] lhs, rhs;
        r2  = longint'(radius) * longint'(radius);
        wx  = longint'(ctr_x) - longint'(a.x);
        wy  = longint'(ctr_y) - longint'(a.y);
        wz  = longint'(ctr_z) - longint'(a.z);
        wa2 = wx * wx + wy * wy + wz * wz;
        dx  = longint'(b.x) - longint'(ctr_x);
        dy  = longint'(b.y) - longint'(ctr_y);
        dz  = longint'(b.z) - longint'(ctr_z);
        wb2 = dx * dx + dy * dy + dz * dz;
        if (wa2 < r2 || wb2 < r2)
            return 1'b1;
        dx = longint'(b.x) - longint'(a.x);
        dy = longint'(b.y) - longint'(a.y);
        dz = longint'(b.z) - longint'(a.z);
        dd = dx * dx + dy * dy + dz * dz;
        dw = dx * wx + dy * wy + dz * wz;
        if (dd <= 0 || dw <= 0 || dw >= dd)
            return 1'b0;
        // closest point strictly inside the segment: compare without division
        lhs = 128'(wa2 - r2) * 128'(dd);
        rhs = 128'(dw) * 128'(dw);
        return lhs < rhs;
    endfunction

    // Advance the polyline state by one accepted point
    task automatic track_point(input point_t pt);
        if (have_prev && segment_touches(prev_pt, pt))
            hit_latch = 1'b1;
        prev_pt   = pt;
        have_prev = 1'b1;
        if (pt.last)
        begin
            collided_due = {collided_due, hit_latch};
            have_prev = 1'b0;
            hit_latch = 1'b0;
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            spl_pkg::CFG_CENTER_X: ctr_x = val;
            spl_pkg::CFG_CENTER_Y: ctr_y = val;
            spl_pkg::CFG_CENTER_Z: ctr_z = val;
            spl_pkg::CFG_RADIUS:   radius = val[RADIUS_W-1:0];
            default:               ;
        endcase
    endtask

    // Monitor: track config and points, check each result word
    always @(posedge clk)
    begin : monitor_b
        point_t pt;
        bit     want;
        s_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (collided_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual collided=%0b",
                             $time, m_axis_tdata[0]);
                    errors++;
                end
                else
                begin
                    want = collided_due.pop_front();
                    if (m_axis_tdata[0] !== want)
                    begin
                        $display("%0t: collided mismatch, expected %0b, actual %0b",
                                 $time, want, m_axis_tdata[0]);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pt.x    = s_axis_tdata[COORD_W-1:0];
                pt.y    = s_axis_tdata[2*COORD_W-1:COORD_W];
                pt.z    = s_axis_tdata[3*COORD_W-1:2*COORD_W];
                pt.last = s_axis_tlast;
                track_point(pt);
            end
        end
    end

    // Driver: offer points in bursts with random gaps
    always @(negedge clk)
    begin : driver_b
        point_t pt;
        bit     offer;
        if (rst_n && (!s_axis_tvalid || s_fire))
        begin
            offer = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_points.size() > 0)
            begin
                pt = pending_points.pop_front();
                s_axis_tdata <= {pt.z, pt.y, pt.x};
                s_axis_tlast <= pt.last;
                offer = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                             : $urandom_range(0, 4);
                end
                else
                    burst_left--;
            end
            s_axis_tvalid <= offer;
        end
    end

    // Receiver: stall pattern that changes each time the 6-bit count wraps, plus one long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                rx_count = rx_count + 1'b1;
                if (rx_count == '0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (rx_count[2:0] != 3'd0);
                endcase
            end
        end
    end

    task automatic push_point(input int x, input int y, input int z, input bit last);
        point_t pt;
        pt.x    = COORD_W'(x);
        pt.y    = COORD_W'(y);
        pt.z    = COORD_W'(z);
        pt.last = last;
        pending_points = {pending_points, pt};
    endtask

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int near_coord(int c, int span);
        return clamp_coord(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_sphere(input int cx, input int cy, input int cz,
                                input logic [CFG_DATA_W-1:0] r);
        write_reg(spl_pkg::CFG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(spl_pkg::CFG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(spl_pkg::CFG_CENTER_Z, CFG_DATA_W'(cz));
        write_reg(spl_pkg::CFG_RADIUS, r);
    endtask

    // Hold until every point is taken and every result is back, then settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || s_axis_tvalid || collided_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic directed_points();
        push_point(0, 0, 0, 1);                 // lone point inside: no segment
        push_point(0, 0, 0, 0);                 // first end inside
        push_point(1000, 1000, 1000, 1);
        push_point(1000, 0, 0, 0);              // second end inside
        push_point(16, 0, 0, 1);
        push_point(-1000, 16, 0, 0);            // middle passes inside
        push_point(1000, 16, 0, 1);
        push_point(-1000, 112, 0, 0);           // grazes the surface only
        push_point(1000, 112, 0, 1);
        push_point(112, 0, 0, 0);               // end sits on the surface
        push_point(1000, 0, 0, 1);
        push_point(50, 0, 0, 0);                // zero-length segment inside
        push_point(50, 0, 0, 1);
        push_point(500, 0, 0, 0);               // zero-length segment outside
        push_point(500, 0, 0, 1);
        push_point(-32768, -32768, -32768, 0);  // longest diagonal through center
        push_point(32767, 32767, 32767, 1);
        push_point(32767, -32768, 32767, 0);
        push_point(-32768, 32767, -32768, 1);
        push_point(-1000, 0, 0, 0);             // early hit stays latched
        push_point(1000, 0, 0, 0);
        push_point(1000, 5000, 0, 0);
        push_point(2000, 5000, 0, 1);
        push_point(3000, 3000, 3000, 0);        // latch cleared for next polyline
        push_point(4000, 4000, 4000, 1);
    endtask

    // Mostly well-formed polylines around the sphere, some raw noise words
    task automatic random_points(input int n_items);
        int kind, len, span, jit, cx, cy, cz, px, py, pz;
        cx   = ctr_x;
        cy   = ctr_y;
        cz   = ctr_z;
        jit  = int'(radius) / 2 + 8;
        for (int sent = 0; sent < n_items; sent += len)
        begin
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 1) == 1) ? int'(radius) + 16 : 3 * int'(radius) + 64;
            if (kind == 0)
            begin
                len = 1;
                push_point(int'($urandom), int'($urandom), int'($urandom),
                           1'($urandom_range(0, 1)));
            end
            else if (kind <= 3)
            begin
                // segment across the center, both ends mirrored with jitter
                len = 2;
                px = near_coord(cx, span);
                py = near_coord(cy, span);
                pz = near_coord(cz, span);
                push_point(px, py, pz, 1'b0);
                push_point(near_coord(clamp_coord(2 * cx - px), jit),
                           near_coord(clamp_coord(2 * cy - py), jit),
                           near_coord(clamp_coord(2 * cz - pz), jit), 1'b1);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    push_point(near_coord(cx, span), near_coord(cy, span),
                               near_coord(cz, span), k == len - 1);
            end
        end
        // close any polyline left open by a noise word
        push_point(near_coord(cx, 3 * int'(radius) + 64), near_coord(cy, 64),
                   near_coord(cz, 64), 1'b1);
    endtask

    // Stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_points();
        wait_drained();

        write_sphere(0, 0, 0, '0);
        random_points(110);
        wait_drained();

        // radius data with bit 15 set: upper bit dropped
        write_sphere(32767, -32768, 32767, 16'hFFFF);
        random_points(110);
        wait_drained();

        write_sphere(-32768, 32767, -32768, 16'd1);
        write_reg(CFG_UNMAPPED, 16'h1234);
        write_reg(CFG_IDX_TOP, 16'hFFFF);
        random_points(110);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_sphere($urandom, $urandom, $urandom,
                         (ph == 5) ? CFG_DATA_W'($urandom_range(0, 32767))
                                   : CFG_DATA_W'($urandom_range(16, 3000)));
            if (ph == 2)
                hold_req = 1'b1;
            random_points(112);
            wait_drained();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/spl_pkg.sv
src/spl_mac.sv
src/spl_seq.sv
src/sphere_polyline_collision.sv
sim/sphere_polyline_collision_tb.sv
